// ===== rtl/core/bmq_pkg.sv =====
// shared types and constants for the blocking message queue
`timescale 1ns / 1ps
package bmq_pkg;

    localparam int TASK_W  = 8;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 4;
    localparam int STAT_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd2;

    // request commands
    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_SENT      = 2'd0;
    localparam logic [STAT_W-1:0] ST_RECEIVED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BLOCKED   = 2'd2;
    localparam logic [STAT_W-1:0] ST_LIST_FULL = 2'd3;

    typedef struct packed {
        logic                      cmd;
        logic [TASK_W-1:0]         task_id;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] read_value;
        logic                      woken_valid;
        logic [TASK_W-1:0]         woken_task;
    } t_result;

    // pointer update requests for one ring
    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

endpackage

// ===== rtl/core/bmq_mem.sv =====
// simple dual-port memory with registered read data
`timescale 1ns / 1ps
module bmq_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bmq_ring.sv =====
// head pointer and fill count of one ring buffer
`timescale 1ns / 1ps
module bmq_ring
    import bmq_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ring_ctl     i_ctl,
    output logic [AW-1:0] o_head,
    output logic [AW-1:0] o_tail,
    output logic [CW-1:0] o_count
);

    localparam int SW = CW + 1;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] sum;

    // head advances on pop, count follows push and pop
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctl.pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop && !i_ctl.push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // slot after the last entry, head plus count wrapped once
    always_comb begin
        sum = SW'(r_head) + SW'(r_count);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
    end

    assign o_head  = r_head;
    assign o_tail  = sum[AW-1:0];
    assign o_count = r_count;

endmodule

// ===== rtl/core/blocking_message_queue.sv =====
// top level: message ring with sender and receiver wait lists
// latency: the result strobe o_done is high in the cycle after start is taken
// requests: no new request is taken while busy is high; busy covers the memory read cycle
// reset: pointers and counts clear, capacity returns to 2; stores stay unset
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps
module blocking_message_queue
    import bmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8,
    parameter int WAIT_DEPTH  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_done,
    output t_result          o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int WAW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WCW  = $clog2(WAIT_DEPTH + 1);
    localparam int CMPW = (QCW > CAP_W) ? QCW : CAP_W;
    localparam int SNDW = TASK_W + VALUE_W;

    logic             r_busy;
    logic [STAT_W-1:0] r_status, n_status;
    logic             r_got_msg, n_got_msg;
    logic             r_wake_rcv, n_wake_rcv;
    logic             r_wake_snd, n_wake_snd;
    logic [CAP_W-1:0] r_capacity;

    logic             accept;
    logic [CMPW-1:0]  cap_eff;
    logic [CMPW-1:0]  msg_cnt_ext;
    logic             msg_room, msg_avail, msg_wake_room;
    logic             snd_avail, snd_full, rcv_avail, rcv_full;

    t_ring_ctl        msg_ctl, snd_ctl, rcv_ctl;
    logic [QAW-1:0]   msg_head, msg_tail;
    logic [QCW-1:0]   msg_count;
    logic [WAW-1:0]   snd_head, snd_tail, rcv_head, rcv_tail;
    logic [WCW-1:0]   snd_count, rcv_count;

    logic             msg_we, msg_re, snd_we, snd_re, rcv_we, rcv_re;
    logic [VALUE_W-1:0] msg_wdata, msg_rdata;
    logic [SNDW-1:0]  snd_rdata;
    logic [TASK_W-1:0] rcv_rdata;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // capacity register, one transfer per valid cycle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    // capacity clamped to the range one to queue depth
    always_comb begin
        cap_eff = CMPW'(r_capacity);
        if (cap_eff == '0) begin
            cap_eff = CMPW'(1);
        end
        if (cap_eff > CMPW'(QUEUE_DEPTH)) begin
            cap_eff = CMPW'(QUEUE_DEPTH);
        end
    end

    // ring occupancy flags
    assign msg_cnt_ext   = CMPW'(msg_count);
    assign msg_room      = msg_cnt_ext < cap_eff;
    assign msg_avail     = msg_count != '0;
    assign msg_wake_room = msg_cnt_ext <= cap_eff;
    assign snd_avail     = snd_count != '0;
    assign snd_full      = snd_count == WCW'(WAIT_DEPTH);
    assign rcv_avail     = rcv_count != '0;
    assign rcv_full      = rcv_count == WCW'(WAIT_DEPTH);

    // request decode at the accepting edge
    always_comb begin
        n_status   = r_status;
        n_got_msg  = 1'b0;
        n_wake_rcv = 1'b0;
        n_wake_snd = 1'b0;
        msg_re     = 1'b0;
        snd_we     = 1'b0;
        snd_re     = 1'b0;
        rcv_we     = 1'b0;
        rcv_re     = 1'b0;
        msg_ctl    = '0;
        snd_ctl    = '0;
        rcv_ctl    = '0;
        if (accept) begin
            unique case (i_req.cmd)
                CMD_SEND: begin
                    if (msg_room) begin
                        n_status     = ST_SENT;
                        msg_ctl.push = 1'b1;
                        if (rcv_avail) begin
                            n_wake_rcv  = 1'b1;
                            rcv_re      = 1'b1;
                            rcv_ctl.pop = 1'b1;
                        end
                    end else if (snd_full) begin
                        n_status = ST_LIST_FULL;
                    end else begin
                        n_status     = ST_BLOCKED;
                        snd_we       = 1'b1;
                        snd_ctl.push = 1'b1;
                    end
                end
                CMD_RECV: begin
                    if (msg_avail) begin
                        n_status    = ST_RECEIVED;
                        n_got_msg   = 1'b1;
                        msg_re      = 1'b1;
                        msg_ctl.pop = 1'b1;
                        if (snd_avail && msg_wake_room) begin
                            n_wake_snd  = 1'b1;
                            snd_re      = 1'b1;
                            snd_ctl.pop = 1'b1;
                        end
                    end else if (rcv_full) begin
                        n_status = ST_LIST_FULL;
                    end else begin
                        n_status     = ST_BLOCKED;
                        rcv_we       = 1'b1;
                        rcv_ctl.push = 1'b1;
                    end
                end
                default: begin
                    n_status = r_status;
                end
            endcase
        end else if (r_busy && r_wake_snd) begin
            // woken sender's stored value enters the ring
            msg_ctl.push = 1'b1;
        end
    end

    // message ring write: new value on send, woken sender's value in the following cycle
    assign msg_we    = msg_ctl.push;
    assign msg_wdata = r_busy ? snd_rdata[VALUE_W-1:0] : i_req.value;

    // request registers, busy for the read cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_status   <= ST_SENT;
            r_got_msg  <= 1'b0;
            r_wake_rcv <= 1'b0;
            r_wake_snd <= 1'b0;
        end else begin
            r_busy     <= accept;
            r_status   <= n_status;
            r_got_msg  <= n_got_msg;
            r_wake_rcv <= n_wake_rcv;
            r_wake_snd <= n_wake_snd;
        end
    end

    // pointer units
    bmq_ring #(.DEPTH(QUEUE_DEPTH)) u_msg_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (msg_ctl),
        .o_head  (msg_head),
        .o_tail  (msg_tail),
        .o_count (msg_count)
    );

    bmq_ring #(.DEPTH(WAIT_DEPTH)) u_snd_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (snd_ctl),
        .o_head  (snd_head),
        .o_tail  (snd_tail),
        .o_count (snd_count)
    );

    bmq_ring #(.DEPTH(WAIT_DEPTH)) u_rcv_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rcv_ctl),
        .o_head  (rcv_head),
        .o_tail  (rcv_tail),
        .o_count (rcv_count)
    );

    // storage
    bmq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(VALUE_W)) u_msg_mem (
        .i_clk   (i_clk),
        .i_we    (msg_we),
        .i_waddr (msg_tail),
        .i_wdata (msg_wdata),
        .i_re    (msg_re),
        .i_raddr (msg_head),
        .o_rdata (msg_rdata)
    );

    bmq_mem #(.DEPTH(WAIT_DEPTH), .WIDTH(SNDW)) u_snd_mem (
        .i_clk   (i_clk),
        .i_we    (snd_we),
        .i_waddr (snd_tail),
        .i_wdata ({i_req.task_id, i_req.value}),
        .i_re    (snd_re),
        .i_raddr (snd_head),
        .o_rdata (snd_rdata)
    );

    bmq_mem #(.DEPTH(WAIT_DEPTH), .WIDTH(TASK_W)) u_rcv_mem (
        .i_clk   (i_clk),
        .i_we    (rcv_we),
        .i_waddr (rcv_tail),
        .i_wdata (i_req.task_id),
        .i_re    (rcv_re),
        .i_raddr (rcv_head),
        .o_rdata (rcv_rdata)
    );

    // result transfer in the cycle after accept
    assign o_done = r_busy;

    always_comb begin
        o_result.status      = r_status;
        o_result.read_value  = r_got_msg ? msg_rdata : '0;
        o_result.woken_valid = r_wake_rcv || r_wake_snd;
        if (r_wake_rcv) begin
            o_result.woken_task = rcv_rdata;
        end else if (r_wake_snd) begin
            o_result.woken_task = snd_rdata[SNDW-1:VALUE_W];
        end else begin
            o_result.woken_task = '0;
        end
    end

endmodule
